### rtl/core/lru_cache_bank_tag_store_assert.svh
// Assertion macros used by the tag store checker.
`ifndef LRU_CACHE_BANK_TAG_STORE_ASSERT_SVH
`define LRU_CACHE_BANK_TAG_STORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCBTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tag store check failed");

// Consequent must hold in the cycle after the antecedent.
`define LCBTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tag store check failed");

`endif

### rtl/core/lcbts_pkg.sv
// Package with sizes, codes and types of the cache bank tag store.
package lcbts_pkg;

    localparam int NUM_LINES  = 256;
    localparam int IDX_W      = $clog2(NUM_LINES);
    localparam int ADDR_BITS  = 48;
    localparam int STAMP_BITS = 31;
    localparam int CNT_W      = 2;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_LINES - 1);
    localparam logic [CNT_W-1:0] COUNT_MAX  = 2'd3;
    localparam logic [CNT_W-1:0] COUNT_INIT = 2'd1;
    localparam logic [CNT_W-1:0] COUNT_ZERO = 2'd0;

    // Command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_MOVE   = 2'd3;

    // Direction codes
    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_EAST  = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [STAMP_BITS-1:0] stamp;
        logic [CNT_W-1:0]      vert;
        logic [CNT_W-1:0]      horz;
    } t_entry;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [STAMP_BITS-1:0] stamp;
    } t_cand;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_BITS-1:0]  addr;
        logic [STAMP_BITS-1:0] stamp;
    } t_best;

    typedef struct packed {
        logic match;
        logic better;
    } t_cmp;

    typedef struct packed {
        logic                  hit;
        logic [CNT_W-1:0]      vertical_count;
        logic [CNT_W-1:0]      horizontal_count;
        logic                  oldest_valid;
        logic [ADDR_BITS-1:0]  oldest_address;
        logic [STAMP_BITS-1:0] oldest_stamp;
        logic                  evicted;
        logic [ADDR_BITS-1:0]  evicted_address;
    } t_rsp;

endpackage

### rtl/core/lcbts_if.sv
// Request and response channel interfaces of the tag store.
interface lcbts_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        command;
    logic [lcbts_pkg::ADDR_BITS-1:0]   line_address;
    logic [lcbts_pkg::STAMP_BITS-1:0]  stamp;
    logic [1:0]                        direction;

    modport source (output valid, command, line_address, stamp, direction, input ready);
    modport sink   (input valid, command, line_address, stamp, direction, output ready);
endinterface

interface lcbts_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [lcbts_pkg::CNT_W-1:0]       vertical_count;
    logic [lcbts_pkg::CNT_W-1:0]       horizontal_count;
    logic                              oldest_valid;
    logic [lcbts_pkg::ADDR_BITS-1:0]   oldest_address;
    logic [lcbts_pkg::STAMP_BITS-1:0]  oldest_stamp;
    logic                              evicted;
    logic [lcbts_pkg::ADDR_BITS-1:0]   evicted_address;

    modport source (output valid, hit, vertical_count, horizontal_count, oldest_valid,
                    oldest_address, oldest_stamp, evicted, evicted_address,
                    input ready);
    modport sink   (input valid, hit, vertical_count, horizontal_count, oldest_valid,
                    oldest_address, oldest_stamp, evicted, evicted_address,
                    output ready);
endinterface

### rtl/core/lcbts_cmp.sv
// Shared compare unit: address match and oldest-line ordering.
module lcbts_cmp (
    input  logic [lcbts_pkg::ADDR_BITS-1:0] i_key_addr,
    input  lcbts_pkg::t_cand                i_cand,
    input  lcbts_pkg::t_best                i_best,
    output lcbts_pkg::t_cmp                 o_res
);

    logic stamp_lt;
    logic stamp_eq;
    logic addr_lt;

    // Order by stamp, then by address
    assign stamp_lt = i_cand.stamp < i_best.stamp;
    assign stamp_eq = i_cand.stamp == i_best.stamp;
    assign addr_lt  = i_cand.addr < i_best.addr;

    assign o_res = '{match:  i_cand.addr == i_key_addr,
                     better: !i_best.valid || stamp_lt || (stamp_eq && addr_lt)};

endmodule

### rtl/core/lcbts_tag_ram.sv
// Line entry memory: one write port, one registered read port.
module lcbts_tag_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [lcbts_pkg::IDX_W-1:0]   i_waddr,
    input  lcbts_pkg::t_entry             i_wdata,
    input  logic                          i_re,
    input  logic [lcbts_pkg::IDX_W-1:0]   i_raddr,
    output lcbts_pkg::t_entry             o_rdata
);

    lcbts_pkg::t_entry r_mem [lcbts_pkg::NUM_LINES];
    lcbts_pkg::t_entry r_rdata;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read entry
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lru_cache_bank_tag_store.sv
// Top level of the fully associative cache bank tag store.
//
// Channel  Dir  Handshake      Carries
// i_req    in   valid/ready    command, line_address, stamp, direction
// o_rsp    out  valid/ready    hit, counters, oldest line, evicted line
//
// An item is taken only while the sequencer is idle. One pass over all
// NUM_LINES entries of the tag memory, one entry per cycle, finds the match,
// the first free entry and the oldest line. An insert into a non-full bank
// adds a merge step, and a second pass follows when an eviction or a remove
// takes away the oldest line.
// Valid bits are flip-flops cleared by reset; the memory needs no clearing.
// A result waiting in the output register holds; the next item may enter.
module lru_cache_bank_tag_store (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcbts_req_if.sink    i_req,
    lcbts_rsp_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_MERGE,
        S_OUT
    } t_state;

    t_state r_state;

    // Pass control
    logic [lcbts_pkg::IDX_W-1:0]      r_idx;
    logic                             r_issuing;
    logic                             r_rd_vld;
    logic [lcbts_pkg::IDX_W-1:0]      r_rd_idx;
    logic                             r_rescan;

    // Captured item
    logic [1:0]                       r_cmd;
    logic [lcbts_pkg::ADDR_BITS-1:0]  r_key_addr;
    logic [lcbts_pkg::STAMP_BITS-1:0] r_key_stamp;
    logic [1:0]                       r_dir;

    // Pass results
    logic                             r_hit;
    logic [lcbts_pkg::IDX_W-1:0]      r_m_idx;
    logic [lcbts_pkg::STAMP_BITS-1:0] r_m_stamp;
    logic [lcbts_pkg::CNT_W-1:0]      r_m_vert;
    logic [lcbts_pkg::CNT_W-1:0]      r_m_horz;
    logic                             r_free_found;
    logic [lcbts_pkg::IDX_W-1:0]      r_free_idx;
    lcbts_pkg::t_best                 r_best;
    logic [lcbts_pkg::IDX_W-1:0]      r_best_idx;

    // Result under construction
    logic                             r_evicted;
    logic [lcbts_pkg::ADDR_BITS-1:0]  r_evict_addr;
    logic [lcbts_pkg::CNT_W-1:0]      r_res_vert;
    logic [lcbts_pkg::CNT_W-1:0]      r_res_horz;

    logic [lcbts_pkg::NUM_LINES-1:0]  r_valid;

    logic                             r_out_valid;
    lcbts_pkg::t_rsp                  r_out;

    // Memory and compare unit hookup
    logic                             ram_we;
    logic [lcbts_pkg::IDX_W-1:0]      ram_waddr;
    lcbts_pkg::t_entry                ram_wdata;
    logic                             ram_re;
    lcbts_pkg::t_entry                ram_rdata;
    lcbts_pkg::t_cand                 cand;
    lcbts_pkg::t_cmp                  cmp;
    logic                             scan_v;
    logic [lcbts_pkg::IDX_W-1:0]      slot;
    logic [lcbts_pkg::CNT_W-1:0]      mv_vert;
    logic [lcbts_pkg::CNT_W-1:0]      mv_horz;
    logic                             evict;

    // Step one counter of the matched line, saturating at both ends
    always_comb begin
        mv_vert = r_m_vert;
        mv_horz = r_m_horz;
        unique case (r_dir)
            lcbts_pkg::DIR_NORTH: begin
                if (r_m_vert != lcbts_pkg::COUNT_ZERO) mv_vert = r_m_vert - 2'd1;
            end
            lcbts_pkg::DIR_SOUTH: begin
                if (r_m_vert != lcbts_pkg::COUNT_MAX) mv_vert = r_m_vert + 2'd1;
            end
            lcbts_pkg::DIR_EAST: begin
                if (r_m_horz != lcbts_pkg::COUNT_ZERO) mv_horz = r_m_horz - 2'd1;
            end
            default: begin
                if (r_m_horz != lcbts_pkg::COUNT_MAX) mv_horz = r_m_horz + 2'd1;
            end
        endcase
    end

    // New line goes to the first free entry, or over the victim when full
    assign slot = r_free_found ? r_free_idx : r_best_idx;

    // Insert of a missing line into a full bank evicts the oldest line
    assign evict = (r_cmd == lcbts_pkg::CMD_INSERT) && !r_hit && !r_free_found;

    // Drive the single write port in the update step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = '{addr: r_key_addr, stamp: r_key_stamp,
                      vert: lcbts_pkg::COUNT_INIT, horz: lcbts_pkg::COUNT_INIT};
        if (r_state == S_UPDATE) begin
            if (r_cmd == lcbts_pkg::CMD_INSERT && !r_hit) begin
                ram_we = 1'b1;
            end else if (r_cmd == lcbts_pkg::CMD_MOVE && r_hit) begin
                ram_we    = 1'b1;
                ram_waddr = r_m_idx;
                ram_wdata = '{addr: r_key_addr, stamp: r_m_stamp,
                              vert: mv_vert, horz: mv_horz};
            end
        end
    end

    assign ram_re = (r_state == S_SCAN) && r_issuing;
    assign scan_v = r_valid[r_rd_idx];

    // Compare unit sees the new line when merging, else the entry read back
    always_comb begin
        if (r_state == S_MERGE) begin
            cand = '{addr: r_key_addr, stamp: r_key_stamp};
        end else begin
            cand = '{addr: ram_rdata.addr, stamp: ram_rdata.stamp};
        end
    end

    lcbts_tag_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    lcbts_cmp u_cmp (
        .i_key_addr (r_key_addr),
        .i_cand     (cand),
        .i_best     (r_best),
        .o_res      (cmp)
    );

    // Sequencer, line state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            // Drop a taken item unless the output step loads the next one
            if (r_out_valid && o_rsp.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= ram_re;
            r_rd_idx <= r_idx;

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd        <= i_req.command;
                        r_key_addr   <= i_req.line_address;
                        r_key_stamp  <= i_req.stamp;
                        r_dir        <= i_req.direction;
                        r_idx        <= '0;
                        r_issuing    <= 1'b1;
                        r_rescan     <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_best       <= '0;
                        r_state      <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    // Advance the read address
                    if (r_issuing) begin
                        r_idx <= r_idx + lcbts_pkg::IDX_W'(1);
                        if (r_idx == lcbts_pkg::LAST_IDX) begin
                            r_issuing <= 1'b0;
                        end
                    end
                    // Examine the entry read back
                    if (r_rd_vld) begin
                        if (scan_v) begin
                            if (!r_rescan && cmp.match && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_m_idx   <= r_rd_idx;
                                r_m_stamp <= ram_rdata.stamp;
                                r_m_vert  <= ram_rdata.vert;
                                r_m_horz  <= ram_rdata.horz;
                            end
                            if (cmp.better) begin
                                r_best     <= '{valid: 1'b1, addr: ram_rdata.addr,
                                                stamp: ram_rdata.stamp};
                                r_best_idx <= r_rd_idx;
                            end
                        end else if (!r_rescan && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_rd_idx;
                        end
                        if (r_rd_idx == lcbts_pkg::LAST_IDX) begin
                            r_state <= r_rescan ? S_OUT : S_UPDATE;
                        end
                    end
                end

                S_UPDATE: begin
                    r_evicted    <= evict;
                    r_evict_addr <= evict ? r_best.addr : '0;
                    unique case (r_cmd)
                        lcbts_pkg::CMD_INSERT: begin
                            if (r_hit) begin
                                r_res_vert <= r_m_vert;
                                r_res_horz <= r_m_horz;
                                r_state    <= S_OUT;
                            end else begin
                                r_valid[slot] <= 1'b1;
                                r_res_vert    <= lcbts_pkg::COUNT_INIT;
                                r_res_horz    <= lcbts_pkg::COUNT_INIT;
                                if (evict) begin
                                    // Evict the oldest line, then find the new oldest
                                    r_idx     <= '0;
                                    r_issuing <= 1'b1;
                                    r_rescan  <= 1'b1;
                                    r_best    <= '0;
                                    r_state   <= S_SCAN;
                                end else begin
                                    r_state <= S_MERGE;
                                end
                            end
                        end
                        lcbts_pkg::CMD_REMOVE: begin
                            r_res_vert <= lcbts_pkg::COUNT_ZERO;
                            r_res_horz <= lcbts_pkg::COUNT_ZERO;
                            if (r_hit) begin
                                r_valid[r_m_idx] <= 1'b0;
                            end
                            // Removing the oldest line needs a second pass
                            if (r_hit && r_m_idx == r_best_idx) begin
                                r_idx     <= '0;
                                r_issuing <= 1'b1;
                                r_rescan  <= 1'b1;
                                r_best    <= '0;
                                r_state   <= S_SCAN;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        lcbts_pkg::CMD_MOVE: begin
                            r_res_vert <= r_hit ? mv_vert : lcbts_pkg::COUNT_ZERO;
                            r_res_horz <= r_hit ? mv_horz : lcbts_pkg::COUNT_ZERO;
                            r_state    <= S_OUT;
                        end
                        lcbts_pkg::CMD_LOOKUP: begin
                            r_res_vert <= r_hit ? r_m_vert : lcbts_pkg::COUNT_ZERO;
                            r_res_horz <= r_hit ? r_m_horz : lcbts_pkg::COUNT_ZERO;
                            r_state    <= S_OUT;
                        end
                    endcase
                end

                S_MERGE: begin
                    // Fold the new line into the oldest-line candidate
                    if (cmp.better) begin
                        r_best <= '{valid: 1'b1, addr: r_key_addr, stamp: r_key_stamp};
                    end
                    r_state <= S_OUT;
                end

                S_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{hit: r_hit,
                                         vertical_count: r_res_vert,
                                         horizontal_count: r_res_horz,
                                         oldest_valid: r_best.valid,
                                         oldest_address: r_best.addr,
                                         oldest_stamp: r_best.stamp,
                                         evicted: r_evicted,
                                         evicted_address: r_evict_addr};
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.hit              = r_out.hit;
    assign o_rsp.vertical_count   = r_out.vertical_count;
    assign o_rsp.horizontal_count = r_out.horizontal_count;
    assign o_rsp.oldest_valid     = r_out.oldest_valid;
    assign o_rsp.oldest_address   = r_out.oldest_address;
    assign o_rsp.oldest_stamp     = r_out.oldest_stamp;
    assign o_rsp.evicted          = r_out.evicted;
    assign o_rsp.evicted_address  = r_out.evicted_address;

endmodule

### rtl/core/lcbts_checker.sv
// Port checker of the tag store and its bind to the top level.
`include "lru_cache_bank_tag_store_assert.svh"

module lcbts_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic                             i_rsp_hit,
    input logic                             i_rsp_oldest_valid,
    input logic [lcbts_pkg::ADDR_BITS-1:0]  i_rsp_oldest_address,
    input logic [lcbts_pkg::STAMP_BITS-1:0] i_rsp_oldest_stamp,
    input logic                             i_rsp_evicted,
    input logic [lcbts_pkg::ADDR_BITS-1:0]  i_rsp_evicted_address
);

    // Hold a pending result until taken
    `LCBTS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // Drop ready once an item is taken
    `LCBTS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // An eviction leaves a full bank and comes only from a missing line
    `LCBTS_ASSERT_NOW(a_evict_full, i_clk, i_rst_n, i_rsp_valid && i_rsp_evicted, i_rsp_oldest_valid && !i_rsp_hit)

    // An empty bank reports zeros and no eviction
    `LCBTS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_oldest_valid, i_rsp_oldest_address == '0 && i_rsp_oldest_stamp == '0 && !i_rsp_evicted && i_rsp_evicted_address == '0)

endmodule

bind lru_cache_bank_tag_store lcbts_checker u_lcbts_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_valid           (i_req.valid),
    .i_req_ready           (i_req.ready),
    .i_rsp_valid           (o_rsp.valid),
    .i_rsp_ready           (o_rsp.ready),
    .i_rsp_hit             (o_rsp.hit),
    .i_rsp_oldest_valid    (o_rsp.oldest_valid),
    .i_rsp_oldest_address  (o_rsp.oldest_address),
    .i_rsp_oldest_stamp    (o_rsp.oldest_stamp),
    .i_rsp_evicted         (o_rsp.evicted),
    .i_rsp_evicted_address (o_rsp.evicted_address)
);
